/* hdl/frame_sync_deframer_top_macros.svh */
`ifndef FRAME_SYNC_DEFRAMER_TOP_MACROS_SVH
`define FRAME_SYNC_DEFRAMER_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset
`define FSD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsd implication failed");

// Signal must stay high into the next cycle while stalled
`define FSD_ASSERT_HOLD(lbl, vld, rdy) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ((vld) && !(rdy)) |=> (vld)) \
    else $error("fsd valid dropped while stalled");

`endif

/* hdl/fsd_pkg.sv */
package fsd_pkg;

  // Frame layout sizes
  localparam int unsigned HEADER_BYTES  = 4;
  localparam int unsigned TRAILER_BYTES = 4;

  // Receive phases
  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_CONF  = 3'd2,
    PH_PAY   = 3'd3,
    PH_TRAIL = 3'd4
  } phase_t;

  // Result event codes
  localparam logic [2:0] EV_PAYLOAD   = 3'd0;
  localparam logic [2:0] EV_GOOD      = 3'd1;
  localparam logic [2:0] EV_SIZE_ERR  = 3'd2;
  localparam logic [2:0] EV_CONF_ERR  = 3'd3;
  localparam logic [2:0] EV_TRAIL_ERR = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_HEADER  = 2'd0;
  localparam logic [1:0] CFG_TRAILER = 2'd1;
  localparam logic [1:0] CFG_MAP     = 2'd2;
  localparam logic [1:0] CFG_MAX     = 2'd3;

  // Pick byte idx out of a 32-bit word
  function automatic logic [7:0] byte_sel(input logic [31:0] word, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = word[7:0];
      2'd1:    b = word[15:8];
      2'd2:    b = word[23:16];
      default: b = word[31:24];
    endcase
    return b;
  endfunction

endpackage

/* hdl/frame_sync_deframer_top.sv */
// Byte-serial frame synchronizer: header, 4-byte little-endian length, 4-byte
// permuted confirmation copy, payload, trailer.
// Input channel (in_valid/in_ready/in_rx_byte) takes one link byte per beat.
// Result channel (out_valid/out_ready) carries event code, payload byte and
// declared frame length; header and early trailer bytes give no result beat;
// length and confirmation bytes give one only when their check fails.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
// header pattern, trailer pattern, confirmation byte map and size limit; it is
// always ready and should be used while the block is idle.
// A byte accepted into the input register is processed into the frame state
// and the result register, and its result beat is presented from the result
// register. One byte per cycle is sustained while the receiver does not stall,
// as the phase update between the input and result registers is combinational.
// Reset (rst_n low, synchronous) returns the block to header hunting and loads
// the register defaults. When the receiver stalls, the result register holds
// and a byte that needs to produce a result waits in the input register; bytes
// that produce no result keep flowing, and in_ready drops once both are full.
module frame_sync_deframer_top
  import fsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_payload_byte,
  output logic [23:0] out_frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers
  logic [31:0] header_pattern_r;
  logic [31:0] trailer_pattern_r;
  logic [7:0]  size_shift_map_r;
  logic [23:0] max_frame_bytes_r;

  // Frame state
  phase_t      phase_r, phase_nxt;
  logic [2:0]  match_cnt_r, match_cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [23:0] conf_r, conf_nxt;
  logic [23:0] cnt_r, cnt_nxt;
  logic        trl_ok_r, trl_ok_nxt;

  // Input register
  logic        in_vld_r;
  logic [7:0]  in_byte_r;

  // Result register
  logic        out_valid_r;
  logic [2:0]  out_event_r;
  logic [7:0]  out_payload_r;
  logic [23:0] out_length_r;

  // Per-byte decode
  logic        res_vld;
  logic [2:0]  res_ev;
  logic [7:0]  res_pb;
  logic [23:0] res_len;
  logic        s1_go;
  logic [23:0] cnt_inc;
  logic [2:0]  match_inc;
  logic [31:0] len_full;
  logic [31:0] conf_full;
  logic        last4;
  logic        hdr_hit;
  logic        len_big;
  logic        conf_ok;
  logic        trl_hit;
  logic        trl_ok_now;

  assign cfg_ready = 1'b1;

  // Advance the input register when its result, if any, has room
  assign s1_go    = in_vld_r && (!res_vld || !out_valid_r || out_ready);
  assign in_ready = !in_vld_r || s1_go;

  assign cnt_inc    = cnt_r + 24'd1;
  assign match_inc  = match_cnt_r + 3'd1;
  assign last4      = (cnt_r[1:0] == 2'd3);
  assign len_full   = {in_byte_r, len_r[23:0]};
  assign conf_full  = {in_byte_r, conf_r};
  assign hdr_hit    = (in_byte_r == byte_sel(header_pattern_r, match_cnt_r[1:0]));
  assign len_big    = (len_full >= {8'd0, max_frame_bytes_r});
  assign trl_hit    = (in_byte_r == byte_sel(trailer_pattern_r, cnt_r[1:0]));
  assign trl_ok_now = trl_ok_r && trl_hit;

  // Check each length byte against its mapped confirmation position
  always_comb begin
    conf_ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (byte_sel(conf_full, size_shift_map_r[2*i +: 2]) != byte_sel(len_r, 2'(i))) begin
        conf_ok = 1'b0;
      end
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_LEN: begin
        if (last4) begin
          phase_nxt = len_big ? PH_HUNT : PH_CONF;
        end
      end
      PH_CONF: begin
        if (last4) begin
          if (!conf_ok) begin
            phase_nxt = PH_HUNT;
          end else if (len_r == 32'd0) begin
            phase_nxt = PH_TRAIL;
          end else begin
            phase_nxt = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        if ({8'd0, cnt_inc} >= len_r) begin
          phase_nxt = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        if (cnt_inc >= 24'(TRAILER_BYTES)) begin
          phase_nxt = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (hdr_hit && (match_inc >= 3'(HEADER_BYTES))) begin
          phase_nxt = PH_LEN;
        end
      end
    endcase
  end

  // Datapath updates and result decode
  always_comb begin
    match_cnt_nxt = match_cnt_r;
    len_nxt       = len_r;
    conf_nxt      = conf_r;
    cnt_nxt       = cnt_r;
    trl_ok_nxt    = trl_ok_r;
    res_vld       = 1'b0;
    res_ev        = EV_PAYLOAD;
    res_pb        = 8'd0;
    res_len       = 24'd0;
    case (phase_r)
      PH_LEN: begin
        len_nxt[{cnt_r[1:0], 3'b000} +: 8] = in_byte_r;
        cnt_nxt = cnt_inc;
        if (last4) begin
          cnt_nxt = 24'd0;
          if (len_big) begin
            match_cnt_nxt = 3'd0;
            trl_ok_nxt    = 1'b1;
            res_vld       = 1'b1;
            res_ev        = EV_SIZE_ERR;
          end
        end
      end
      PH_CONF: begin
        if (!last4) begin
          conf_nxt[{cnt_r[1:0], 3'b000} +: 8] = in_byte_r;
        end
        cnt_nxt = cnt_inc;
        if (last4) begin
          cnt_nxt       = 24'd0;
          trl_ok_nxt    = 1'b1;
          match_cnt_nxt = 3'd0;
          if (!conf_ok) begin
            res_vld = 1'b1;
            res_ev  = EV_CONF_ERR;
          end
        end
      end
      PH_PAY: begin
        cnt_nxt = cnt_inc;
        if ({8'd0, cnt_inc} >= len_r) begin
          cnt_nxt = 24'd0;
        end
        res_vld = 1'b1;
        res_ev  = EV_PAYLOAD;
        res_pb  = in_byte_r;
      end
      PH_TRAIL: begin
        trl_ok_nxt = trl_ok_now;
        cnt_nxt    = cnt_inc;
        if (cnt_inc >= 24'(TRAILER_BYTES)) begin
          cnt_nxt       = 24'd0;
          match_cnt_nxt = 3'd0;
          trl_ok_nxt    = 1'b1;
          res_vld       = 1'b1;
          res_ev        = trl_ok_now ? EV_GOOD : EV_TRAIL_ERR;
          res_len       = len_r[23:0];
        end
      end
      default: begin
        if (hdr_hit) begin
          match_cnt_nxt = match_inc;
          if (match_inc >= 3'(HEADER_BYTES)) begin
            match_cnt_nxt = 3'd0;
            cnt_nxt       = 24'd0;
          end
        end else begin
          match_cnt_nxt = 3'd0;
        end
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_pattern_r  <= 32'd0;
      trailer_pattern_r <= 32'd0;
      size_shift_map_r  <= 8'd228;
      max_frame_bytes_r <= 24'd16384;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HEADER:  header_pattern_r  <= cfg_data;
        CFG_TRAILER: trailer_pattern_r <= cfg_data;
        CFG_MAP:     size_shift_map_r  <= cfg_data[7:0];
        CFG_MAX:     max_frame_bytes_r <= cfg_data[23:0];
        default:     header_pattern_r  <= header_pattern_r;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Frame state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      match_cnt_r <= 3'd0;
      len_r       <= 32'd0;
      conf_r      <= 24'd0;
      cnt_r       <= 24'd0;
      trl_ok_r    <= 1'b1;
    end else if (s1_go) begin
      phase_r     <= phase_nxt;
      match_cnt_r <= match_cnt_nxt;
      len_r       <= len_nxt;
      conf_r      <= conf_nxt;
      cnt_r       <= cnt_nxt;
      trl_ok_r    <= trl_ok_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && res_vld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_vld) begin
      out_event_r   <= res_ev;
      out_payload_r <= res_pb;
      out_length_r  <= res_len;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_event_r;
  assign out_payload_byte = out_payload_r;
  assign out_frame_length = out_length_r;

endmodule

/* hdl/fsd_checker.sv */
`include "frame_sync_deframer_top_macros.svh"

module fsd_checker
  import fsd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_event_res,
  input logic [7:0]  out_payload_byte,
  input logic [23:0] out_frame_length
);

  // Stalled result beat stays offered
  `FSD_ASSERT_HOLD(a_out_hold, out_valid, out_ready)

  // Only defined event codes leave the block
  `FSD_ASSERT_IMPL(a_ev_range, out_valid, (out_event_res <= EV_TRAIL_ERR))

  // Payload byte is zero on status beats
  `FSD_ASSERT_IMPL(a_pb_zero, out_valid && (out_event_res != EV_PAYLOAD), (out_payload_byte == 8'd0))

  // Length is reported only with frame end status
  `FSD_ASSERT_IMPL(a_len_zero, out_valid && (out_event_res != EV_GOOD) && (out_event_res != EV_TRAIL_ERR), (out_frame_length == 24'd0))

endmodule

bind frame_sync_deframer_top fsd_checker u_fsd_checker (.*);
